>>> hdl/cq216_pkg.sv
// Shared types, register indexes and level functions for the 6x6x6 color cube quantizer.
// No dependencies; used by all modules of the quantizer.
`default_nettype none
package cq216_pkg;

  localparam int PIX_W   = 24;
  localparam int IDX_W   = 8;
  localparam int LVL_W   = 3;
  localparam int FLD_W   = 5;
  localparam int SCL_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 1'd1;

  localparam logic [IDX_W-1:0] IDX_MAX = 8'd215;

  // position inside the 2x2 dither cell, bit 1 = row, bit 0 = column
  typedef logic [1:0] cq216_pos_t;
  localparam cq216_pos_t POS_UL = 2'd0;
  localparam cq216_pos_t POS_UR = 2'd1;
  localparam cq216_pos_t POS_LL = 2'd2;
  localparam cq216_pos_t POS_LR = 2'd3;

  typedef struct packed {
    logic source_format;
    logic dither_enable;
  } cq216_mode_t;

  // (4v)/21 for a 5-bit field
  function automatic logic [LVL_W-1:0] lvl15(input logic [FLD_W-1:0] v);
    logic [LVL_W-1:0] l;
    l = 3'd0;
    if (v >= 5'd6)  l = 3'd1;
    if (v >= 5'd11) l = 3'd2;
    if (v >= 5'd16) l = 3'd3;
    if (v >= 5'd21) l = 3'd4;
    if (v >= 5'd27) l = 3'd5;
    return l;
  endfunction

  // (v+25)/51 for a byte
  function automatic logic [LVL_W-1:0] lvl24(input logic [7:0] v);
    logic [LVL_W-1:0] l;
    l = 3'd0;
    if (v >= 8'd26)  l = 3'd1;
    if (v >= 8'd77)  l = 3'd2;
    if (v >= 8'd128) l = 3'd3;
    if (v >= 8'd179) l = 3'd4;
    if (v >= 8'd230) l = 3'd5;
    return l;
  endfunction

  // (2v)/3 as v*342 >> 9
  function automatic logic [SCL_W-1:0] dscale(input logic [FLD_W-1:0] v);
    logic [13:0] p;
    p = {9'd0, v} * 14'd342;
    return p[13:9];
  endfunction

  function automatic logic [LVL_W-1:0] dlevel(input logic [SCL_W-1:0] d,
                                              input cq216_pos_t pos);
    logic [SCL_W-1:0] s;
    case (pos)
      POS_UL:  s = d + 5'd3;
      POS_UR:  s = d + 5'd1;
      POS_LL:  s = d;
      POS_LR:  s = d + 5'd2;
      default: s = d;
    endcase
    return s[SCL_W-1:2];
  endfunction

  function automatic logic [IDX_W-1:0] cube_index(input logic [LVL_W-1:0] c0,
                                                  input logic [LVL_W-1:0] c1,
                                                  input logic [LVL_W-1:0] c2);
    return {5'd0, c0} + ({5'd0, c1} * 8'd6) + ({5'd0, c2} * 8'd36);
  endfunction

endpackage
`default_nettype wire

>>> hdl/rgb_to_216_color_quantizer_core.sv
// Top level of the 6x6x6 color cube quantizer: input register, index logic, output register.
// Depends on cq216_pkg and cq216_index.
// Direct modes (24-bit, or 15-bit with dither off) take one pixel per cycle while the output
// is not stalled by out_tready, and give one index each, with out_tlast set. The 15-bit
// dithered mode gives four indices per pixel (upper-left, upper-right, lower-left,
// lower-right; out_tuser marks row and column), so a pixel stays in the input register until
// all four indices have passed, one at a time, into the output register. Write configuration
// only while no pixel is in flight.
`default_nettype none
module rgb_to_216_color_quantizer_core
  import cq216_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // [23:0] pixel_value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [IDX_W-1:0]           out_tdata,  // [7:0] palette_index
  output logic [1:0]                 out_tuser,  // [0] odd_row, [1] odd_column
  output logic                       out_tlast
);

  cq216_mode_t      mode_r, mode_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] pix_r;
  cq216_pos_t       pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic [1:0]       out_user_r;
  logic             out_last_r;

  logic             dith, s1_last, out_free, s1_fire, in_xfer;
  logic [IDX_W-1:0] idx;

  cq216_index u_index (
    .pix  (pix_r),
    .mode (mode_r),
    .pos  (pos_r),
    .idx  (idx)
  );

  assign dith     = mode_r.dither_enable && !mode_r.source_format;
  assign s1_last  = !dith || (pos_r == POS_LR);
  assign out_free = !out_valid_r || out_tready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || (out_free && s1_last);
  assign in_xfer  = in_tvalid && in_tready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_FORMAT: mode_nxt.source_format = cfg_wdata[0];
        CFG_DITHER_ENABLE: mode_nxt.dither_enable = cfg_wdata[0];
        default: ;
      endcase
    end
    s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;
    pos_nxt = pos_r;
    if (s1_fire) begin
      pos_nxt = s1_last ? POS_UL : pos_r + 2'd1;
    end
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      s1_valid_r  <= 1'b0;
      pos_r       <= POS_UL;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_tdata;
    end
    if (s1_fire) begin
      out_idx_r  <= idx;
      out_user_r <= {pos_r[0], pos_r[1]};
      out_last_r <= s1_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> hdl/cq216_index.sv
// Channel level extraction and cube index for one pixel at one cell position.
// Depends on cq216_pkg.
`default_nettype none
module cq216_index
  import cq216_pkg::*;
(
  input  wire logic [PIX_W-1:0] pix,
  input  wire cq216_mode_t      mode,
  input  wire cq216_pos_t       pos,
  output logic [IDX_W-1:0]      idx
);

  logic [FLD_W-1:0] f0, f1, f2;
  logic [LVL_W-1:0] c0, c1, c2;

  assign f0 = pix[9:5];
  assign f1 = pix[14:10];
  assign f2 = pix[4:0];

  always_comb begin
    if (mode.source_format) begin
      c0 = lvl24(pix[7:0]);
      c1 = lvl24(pix[15:8]);
      c2 = lvl24(pix[23:16]);
    end else if (mode.dither_enable) begin
      c0 = dlevel(dscale(f0), pos);
      c1 = dlevel(dscale(f1), pos);
      c2 = dlevel(dscale(f2), pos);
    end else begin
      c0 = lvl15(f0);
      c1 = lvl15(f1);
      c2 = lvl15(f2);
    end
  end

  assign idx = cube_index(c0, c1, c2);

endmodule
`default_nettype wire

>>> hdl/cq216_checker.sv
// Port-level checks for the color cube quantizer, bound to the top level.
// Depends on cq216_pkg.
`default_nettype none
module cq216_checker
  import cq216_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [IDX_W-1:0] out_tdata,
  input wire logic [1:0]       out_tuser,
  input wire logic             out_tlast
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled transfer changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= IDX_MAX)
    else $error("palette index out of range");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == 2'b00 || out_tuser == 2'b11))
    else $error("last transfer at wrong cell position");

  a_lr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'b11 |-> out_tlast)
    else $error("lower-right transfer without last");

endmodule

bind rgb_to_216_color_quantizer_core cq216_checker u_cq216_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
